[rtl/bsd_pkg.sv]
package bsd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_LENGTH  = 3'd2;
  localparam logic [2:0] ST_PADDING = 3'd3;
  localparam logic [2:0] ST_TRAIL   = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
    logic [2:0] status;
  } res_item_t;

  typedef struct packed {
    logic [17:0] acc;
    logic [1:0]  grp;
    logic [1:0]  pad;
    logic        discarding;
  } dec_state_t;

  // Up to three results made by one character, oldest in entry 0.
  typedef struct packed {
    logic [1:0]          count;
    res_item_t [2:0]     items;
  } res_set_t;

  // Returns {not_in_alphabet, sextet}.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

[rtl/bsd_decode.sv]
module bsd_decode (
  input  bsd_pkg::dec_state_t state,
  input  bsd_pkg::char_item_t item,
  output bsd_pkg::dec_state_t state_next,
  output bsd_pkg::res_set_t   results
);
  import bsd_pkg::*;

  logic [6:0]  map;
  logic [23:0] word;
  logic [7:0]  b0, b1, b2;
  logic [1:0]  nb;
  logic [1:0]  n;
  logic        err;
  logic [2:0]  err_status;
  dec_state_t  upd;

  assign map  = sextet_of(item.char_code);
  assign word = {state.acc, map[5:0]};

  // Character handling proper, before the end-of-message checks.
  always_comb begin
    upd        = state;
    nb         = 2'd0;
    b0         = 8'h00;
    b1         = 8'h00;
    b2         = 8'h00;
    err        = 1'b0;
    err_status = ST_OK;
    if (item.char_code == PAD_CHAR) begin
      if (state.grp == 2'd0 && state.pad != 2'd0) begin
        err        = 1'b1;
        err_status = ST_PADDING;
      end else if (state.grp < 2'd2) begin
        err        = 1'b1;
        err_status = ST_LENGTH;
      end else if (state.grp == 2'd2) begin
        upd.acc = {state.acc[11:0], 6'd0};
        upd.pad = 2'd1;
        upd.grp = 2'd3;
      end else if (state.pad == 2'd1) begin
        if (state.acc[9:6] != 4'h0) begin
          err        = 1'b1;
          err_status = ST_TRAIL;
        end else begin
          b0      = state.acc[17:10];
          nb      = 2'd1;
          upd.pad = 2'd2;
          upd.grp = 2'd0;
          upd.acc = '0;
        end
      end else begin
        if (state.acc[1:0] != 2'b00) begin
          err        = 1'b1;
          err_status = ST_TRAIL;
        end else begin
          b0      = state.acc[17:10];
          b1      = state.acc[9:2];
          nb      = 2'd2;
          upd.pad = 2'd1;
          upd.grp = 2'd0;
          upd.acc = '0;
        end
      end
    end else begin
      if (map[6] || state.pad != 2'd0) begin
        err        = 1'b1;
        err_status = ST_INVALID;
      end else if (state.grp == 2'd3) begin
        b0      = word[23:16];
        b1      = word[15:8];
        b2      = word[7:0];
        nb      = 2'd3;
        upd.grp = 2'd0;
        upd.acc = '0;
      end else begin
        upd.acc = word[17:0];
        upd.grp = state.grp + 2'd1;
      end
    end
    if (!err && item.last_char && upd.grp != 2'd0) begin
      err        = 1'b1;
      err_status = ST_LENGTH;
    end
  end

  always_comb begin
    results.items = '0;
    results.items[0].data_byte = b0;
    results.items[1].data_byte = b1;
    results.items[2].data_byte = b2;
    results.items[0].byte_valid = (nb >= 2'd1);
    results.items[1].byte_valid = (nb >= 2'd2);
    results.items[2].byte_valid = (nb == 2'd3);
    state_next = upd;
    n = nb;
    if (state.discarding) begin
      results.items = '0;
      n = 2'd0;
      state_next = state;
      if (item.last_char) begin
        state_next = '0;
      end
    end else if (err) begin
      // An error result carries no byte; the state restarts and later
      // characters are dropped unless this one closes the message.
      results.items = '0;
      results.items[0].message_end = 1'b1;
      results.items[0].status      = err_status;
      n = 2'd1;
      state_next = '0;
      state_next.discarding = !item.last_char;
    end else if (item.last_char) begin
      state_next = '0;
      if (nb == 2'd0) begin
        results.items[0].message_end = 1'b1;
        n = 2'd1;
      end else begin
        results.items[nb - 2'd1].message_end = 1'b1;
      end
    end
    if (n != 2'd0) begin
      results.items[n - 2'd1].run_last = 1'b1;
    end
    results.count = n;
  end

endmodule

[rtl/base64_stream_decoder.sv]
// An accepted character is held in the input register until the queue has room;
// its results are then written to the result queue and offered on res_item.
// Throughput: one character per cycle; four characters give at most three
// bytes, drained one per cycle while not stalled from an eight-entry result
// queue, which stops taking characters when fewer than three entries are free.
// Reset (rst, synchronous): empties the queue and input register, clears state.
module base64_stream_decoder #(
  parameter int QDEPTH_LOG2 = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  bsd_pkg::char_item_t char_item,
  output logic                res_valid,
  input  logic                res_stall,
  output bsd_pkg::res_item_t  res_item
);
  import bsd_pkg::*;

  localparam int QDEPTH = 1 << QDEPTH_LOG2;

  char_item_t  in_item;
  logic        in_full;
  dec_state_t  state;
  dec_state_t  state_next;
  res_set_t    results;
  logic        advance;
  logic        pop;

  res_item_t                queue [QDEPTH];
  logic [QDEPTH_LOG2-1:0]   wr_ptr;
  logic [QDEPTH_LOG2-1:0]   rd_ptr;
  logic [QDEPTH_LOG2:0]     count;

  bsd_decode u_decode (
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .results    (results)
  );

  // Room for the largest burst one character can cause.
  assign advance    = in_full && (count <= (QDEPTH_LOG2 + 1)'(QDEPTH - 3));
  assign char_stall = in_full && !advance;
  assign res_valid  = (count != '0);
  assign res_item   = queue[rd_ptr];
  assign pop        = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      state   <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      if (char_valid && !char_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        state  <= state_next;
        wr_ptr <= wr_ptr + QDEPTH_LOG2'(results.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QDEPTH_LOG2'(1);
      end
      count <= count + (advance ? (QDEPTH_LOG2 + 1)'(results.count) : '0)
                     - (QDEPTH_LOG2 + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_item <= char_item;
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < results.count) begin
          queue[wr_ptr + QDEPTH_LOG2'(i)] <= results.items[i];
        end
      end
    end
  end

endmodule

[rtl/bsd_checker.sv]
module bsd_checker (
  input logic               clk,
  input logic               rst,
  input logic               char_valid,
  input logic               char_stall,
  input bsd_pkg::char_item_t char_item,
  input logic               res_valid,
  input logic               res_stall,
  input bsd_pkg::res_item_t res_item
);
  import bsd_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != ST_OK |-> res_item.message_end)
    else $error("status reported on a result that does not end the message");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.message_end |-> res_item.run_last)
    else $error("message end not on the last result of its character");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.byte_valid |->
      res_item.message_end && res_item.data_byte == 8'h00)
    else $error("result without byte is not a clean message end");

  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_item))
    else $error("character item changed while stalled");

endmodule

bind base64_stream_decoder bsd_checker u_bsd_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_item  (char_item),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_item   (res_item)
);

[tb/sv/tb_base64_stream_decoder.sv]
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
  import bsd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TOTAL_CHARS   = 160;
  localparam int LONG_HOLD     = 150;

  // Tracks the decoder state and holds the results still owed by the block.
  class decode_scoreboard;
    res_item_t   expected_results[$];
    logic [17:0] acc;
    logic [1:0]  grp;
    logic [1:0]  pad;
    logic        skipping;
    int          mismatches;
    int          chars_seen;
    int          useful_chars;
    int          bytes_checked;
    int          ends_checked;
    int          status_count[5];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      acc = '0;
      grp = '0;
      pad = '0;
      skipping = 1'b0;
    endfunction

    function res_item_t byte_result(logic [7:0] b);
      res_item_t r;
      r = '0;
      r.data_byte = b;
      r.byte_valid = 1'b1;
      return r;
    endfunction

    function res_item_t end_result(logic [2:0] code);
      res_item_t r;
      r = '0;
      r.message_end = 1'b1;
      r.status = code;
      return r;
    endfunction

    // Bit 6 set means the character is outside the alphabet.
    function logic [6:0] alphabet_value(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
      if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
      if (c == 8'h2B) return 7'd62;
      if (c == 8'h2F) return 7'd63;
      return 7'h40;
    endfunction

    function void note_char(char_item_t it);
      res_item_t   outs[$];
      logic [6:0]  v;
      logic [23:0] word;
      logic        err;
      logic [2:0]  code;
      err = 1'b0;
      code = ST_OK;
      chars_seen++;
      if (skipping) begin
        if (it.last_char) clear_state();
        return;
      end
      useful_chars++;
      if (it.char_code == PAD_CHAR) begin
        if (grp == 0 && pad != 0) begin
          err = 1'b1;
          code = ST_PADDING;
        end else if (grp < 2) begin
          err = 1'b1;
          code = ST_LENGTH;
        end else if (grp == 2) begin
          acc = {acc[11:0], 6'd0};
          pad = 2'd1;
          grp = 2'd3;
        end else if (pad == 1) begin
          // Second pad of "xx==": the low four bits of the second sextet are unused.
          if (acc[9:6] != 0) begin
            err = 1'b1;
            code = ST_TRAIL;
          end else begin
            outs.push_back(byte_result(acc[17:10]));
            pad = 2'd2;
            grp = 2'd0;
            acc = '0;
          end
        end else begin
          if (acc[1:0] != 0) begin
            err = 1'b1;
            code = ST_TRAIL;
          end else begin
            outs.push_back(byte_result(acc[17:10]));
            outs.push_back(byte_result(acc[9:2]));
            pad = 2'd1;
            grp = 2'd0;
            acc = '0;
          end
        end
      end else begin
        v = alphabet_value(it.char_code);
        if (v[6] || pad != 0) begin
          err = 1'b1;
          code = ST_INVALID;
        end else if (grp == 3) begin
          word = {acc, v[5:0]};
          outs.push_back(byte_result(word[23:16]));
          outs.push_back(byte_result(word[15:8]));
          outs.push_back(byte_result(word[7:0]));
          grp = 2'd0;
          acc = '0;
        end else begin
          acc = {acc[11:0], v[5:0]};
          grp = grp + 2'd1;
        end
      end

      if (!err && it.last_char && grp != 0) begin
        err = 1'b1;
        code = ST_LENGTH;
      end

      if (err) begin
        outs.push_back(end_result(code));
        clear_state();
        skipping = !it.last_char;
      end else if (it.last_char) begin
        if (outs.size() > 0) outs[outs.size() - 1].message_end = 1'b1;
        else outs.push_back(end_result(ST_OK));
        clear_state();
      end

      if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
      foreach (outs[i]) expected_results.push_back(outs[i]);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(res_item_t got);
      res_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
      if (got.byte_valid !== want.byte_valid)
        report_mismatch($sformatf("byte_valid got %b want %b", got.byte_valid,
                                  want.byte_valid));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("run_last got %b want %b", got.run_last, want.run_last));
      if (got.message_end !== want.message_end)
        report_mismatch($sformatf("message_end got %b want %b", got.message_end,
                                  want.message_end));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (want.byte_valid) bytes_checked++;
      if (want.message_end) begin
        ends_checked++;
        if (want.status <= ST_TRAIL) status_count[want.status]++;
      end
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_item_t char_item = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_item_t  res_item;

  decode_scoreboard sb = new();
  logic [7:0] msg_chars[$];
  bit         idling_on = 1'b1;
  bit         hold_req = 1'b0;
  int         stall_left = 0;
  int         cycle_count = 0;

  base64_stream_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each accepted item, then pick the next stall value.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) sb.check_result(res_item);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) res_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
        res_stall <= 1'b1;
      end
    end
  end

  function logic [7:0] sextet_char(logic [5:0] s);
    if (s < 26) return 8'h41 + {2'b00, s};
    if (s < 52) return 8'h61 + {2'b00, s} - 8'd26;
    if (s < 62) return 8'h30 + {2'b00, s} - 8'd52;
    if (s == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  // Fills msg_chars with the padded encoding of nbytes random bytes.
  function void encode_random(int nbytes);
    logic [7:0]  raw[$];
    logic [23:0] w;
    int          rem;
    msg_chars.delete();
    raw.delete();
    for (int i = 0; i < nbytes; i++) raw.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < nbytes; i += 3) begin
      rem = nbytes - i;
      w = {raw[i], (rem > 1) ? raw[i + 1] : 8'h00, (rem > 2) ? raw[i + 2] : 8'h00};
      msg_chars.push_back(sextet_char(w[23:18]));
      msg_chars.push_back(sextet_char(w[17:12]));
      msg_chars.push_back((rem > 1) ? sextet_char(w[11:6]) : PAD_CHAR);
      msg_chars.push_back((rem > 2) ? sextet_char(w[5:0]) : PAD_CHAR);
    end
  endfunction

  function void break_message(int mode);
    int idx;
    int j;
    idx = $urandom_range(0, msg_chars.size() - 1);
    j = msg_chars.size() - 1;
    while (j > 0 && msg_chars[j] == PAD_CHAR) j--;
    case (mode)
      1: begin
        if (msg_chars.size() > 1) void'(msg_chars.pop_back());
      end
      2: msg_chars.insert(idx, PAD_CHAR);
      3: begin
        // Disturb the character just before the padding to leave stray low bits.
        if (j < msg_chars.size() - 1) msg_chars[j] = sextet_char(6'($urandom_range(0, 63)));
        else msg_chars[idx] = 8'($urandom_range(0, 255));
      end
      4: begin
        msg_chars.delete();
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) msg_chars.push_back(8'($urandom_range(0, 255)));
          else if ($urandom_range(0, 4) == 0) msg_chars.push_back(PAD_CHAR);
          else msg_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
        end
      end
      5: msg_chars.push_back(PAD_CHAR);
      default: msg_chars[idx] = 8'($urandom_range(0, 255));
    endcase
  endfunction

  task send_char(input char_item_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item <= it;
    do @(posedge clk); while (char_stall);
    sb.note_char(it);
  endtask

  task send_message();
    char_item_t it;
    for (int i = 0; i < msg_chars.size(); i++) begin
      it.char_code = msg_chars[i];
      it.last_char = (i == msg_chars.size() - 1);
      send_char(it);
    end
  endtask

  task send_text(input string s);
    msg_chars.delete();
    for (int i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
    send_message();
  endtask

  initial begin
    int  target;
    int  nbytes;
    bit  hold_done;
    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Alphabet edges, both padded forms, and each way a message can fail.
    send_text("/+90");
    send_text("TQ==");
    send_text("TWE=");
    send_text("=");
    send_text("TR==");
    send_text("TQ===");
    send_text("TQ=A=");
    send_text("TQ=");

    target = TOTAL_CHARS;
    while (sb.chars_seen < target) begin
      if (target - sb.chars_seen < 35) idling_on = 1'b0;
      else idling_on = ($urandom_range(0, 3) != 0);
      if (!hold_done && target - sb.chars_seen < TOTAL_CHARS / 2) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
      encode_random(nbytes);
      if ($urandom_range(0, 9) < 3) break_message($urandom_range(0, 5));
      send_message();
    end

    char_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters (%0d decoded); checked %0d bytes and %0d message ends.",
             sb.chars_seen, sb.useful_chars, sb.bytes_checked, sb.ends_checked);
    $display("End status counts: ok %0d, invalid %0d, length %0d, padding %0d, trailing %0d.",
             sb.status_count[ST_OK], sb.status_count[ST_INVALID], sb.status_count[ST_LENGTH],
             sb.status_count[ST_PADDING], sb.status_count[ST_TRAIL]);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
